// File: rtl/core/fixed_frame_deframer_dispatch_top_defines.svh
// Assertion macros for the fixed frame deframer.
// Included by the modules that carry concurrent checks.
`ifndef FIXED_FRAME_DEFRAMER_DISPATCH_TOP_DEFINES_SVH
`define FIXED_FRAME_DEFRAMER_DISPATCH_TOP_DEFINES_SVH

// cons must hold in the same cycle as ante
`define FFDD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define FFDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ffdd_pkg.sv
// Shared types and constants of the fixed frame deframer.
// No dependencies.
package ffdd_pkg;

   localparam logic [7:0] START_MARK = 8'h73;
   localparam logic [7:0] END_MARK   = 8'h65;
   localparam int RESULT_CAP = 32;
   localparam int POS_W = 5;
   localparam int TYPES_W = 64;
   localparam int ENABLE_W = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 1;
   localparam int MASK_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SUBSCRIBER_TYPES  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUBSCRIBER_ENABLE = 1'd1;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_transfer;
   } req_payload_type;

   typedef struct packed {
      logic             status;
      logic [7:0]       frame_byte;
      logic [POS_W-1:0] byte_position;
      logic [MASK_W-1:0] ready_mask;
      logic             last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic              fire;
      logic              good;
      logic [MASK_W-1:0] mask;
   } frame_done_type;

   typedef struct packed {
      logic busy;
      logic out_full;
   } emit_status_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_READ,
      EMIT_LOAD
   } emit_state_type;

endpackage

// File: rtl/core/ffdd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ffdd_hunter.sv
// Input side: transfer byte limit, start hunt and frame fill into the frame RAM.
// Depends on ffdd_pkg.
module ffdd_hunter #(
   parameter int FRAME_BYTES    = 32,
   parameter int TRANSFER_LIMIT = 32,
   parameter int SUBSCRIBERS    = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ffdd_pkg::req_payload_type      req_data,
   input  logic [ffdd_pkg::TYPES_W-1:0]   subscriber_types,
   input  logic [ffdd_pkg::ENABLE_W-1:0]  subscriber_enable,
   input  ffdd_pkg::emit_status_type      emit_status,
   output ffdd_pkg::frame_done_type       frame_done,
   output logic                           wr_en,
   output logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
   output logic [7:0]                     wr_data
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int CW = $clog2(TRANSFER_LIMIT + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          collecting_ff, collecting_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [7:0]    byte1_ff, byte1_in;
   logic          in_window, completes, accept;
   logic [ffdd_pkg::MASK_W-1:0] match_mask;

   assign in_window = count_ff < CW'(TRANSFER_LIMIT);
   assign completes = in_window && collecting_ff && (fill_ff == AW'(FRAME_BYTES - 1));
   assign req_stall = emit_status.busy || (completes && emit_status.out_full);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      match_mask = '0;
      for (int i = 0; i < SUBSCRIBERS; i++) begin
         match_mask[i] = subscriber_enable[i] && (subscriber_types[8*i +: 8] == byte1_ff);
      end
   end

   always_comb begin
      count_in      = count_ff;
      collecting_in = collecting_ff;
      fill_in       = fill_ff;
      byte1_in      = byte1_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_ff;
      wr_data       = req_data.rx_byte;
      frame_done.fire = 1'b0;
      frame_done.good = 1'b0;
      frame_done.mask = match_mask;
      if (accept) begin
         if (req_data.end_of_transfer) begin
            count_in = '0;
         end else if (in_window) begin
            count_in = count_ff + CW'(1);
         end
         if (in_window) begin
            if (!collecting_ff) begin
               if (req_data.rx_byte == ffdd_pkg::START_MARK) begin
                  wr_en         = 1'b1;
                  wr_addr       = '0;
                  fill_in       = AW'(1);
                  collecting_in = 1'b1;
               end
            end else begin
               wr_en = 1'b1;
               if (fill_ff == AW'(1)) begin
                  byte1_in = req_data.rx_byte;
               end
               if (completes) begin
                  collecting_in   = 1'b0;
                  fill_in         = '0;
                  frame_done.fire = 1'b1;
                  frame_done.good = req_data.rx_byte == ffdd_pkg::END_MARK;
               end else begin
                  fill_in = fill_ff + AW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         collecting_ff <= 1'b0;
         fill_ff       <= '0;
      end else begin
         count_ff      <= count_in;
         collecting_ff <= collecting_in;
         fill_ff       <= fill_in;
      end
      byte1_ff <= byte1_in;
   end

endmodule

// File: rtl/core/ffdd_emitter.sv
// Result side: ready flags, frame RAM read-out sequencer and output register.
// Depends on ffdd_pkg and the assertion macro header.
`include "fixed_frame_deframer_dispatch_top_defines.svh"

module ffdd_emitter #(
   parameter int FRAME_BYTES = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ffdd_pkg::frame_done_type       frame_done,
   output ffdd_pkg::emit_status_type      emit_status,
   output logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
   input  logic [7:0]                     rd_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ffdd_pkg::rsp_payload_type      rsp_data
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int EMIT_N = (FRAME_BYTES < ffdd_pkg::RESULT_CAP) ? FRAME_BYTES
                                                               : ffdd_pkg::RESULT_CAP;

   ffdd_pkg::emit_state_type     state_ff, state_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic [ffdd_pkg::MASK_W-1:0]  flags_ff, flags_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ffdd_pkg::rsp_payload_type    rsp_data_ff, rsp_data_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ffdd_pkg::EMIT_IDLE: begin
            if (frame_done.fire) begin
               if (frame_done.good) begin
                  flags_in = frame_done.mask;
                  idx_in   = '0;
                  state_in = ffdd_pkg::EMIT_READ;
               end else begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.status        = 1'b1;
                  rsp_data_in.frame_byte    = '0;
                  rsp_data_in.byte_position = '0;
                  rsp_data_in.ready_mask    = flags_ff;
                  rsp_data_in.last_of_run   = 1'b1;
               end
            end
         end
         ffdd_pkg::EMIT_READ: begin
            state_in = ffdd_pkg::EMIT_LOAD;
         end
         ffdd_pkg::EMIT_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = 1'b0;
               rsp_data_in.frame_byte    = rd_data;
               rsp_data_in.byte_position = ffdd_pkg::POS_W'(idx_ff);
               rsp_data_in.ready_mask    = flags_ff;
               rsp_data_in.last_of_run   = idx_ff == AW'(EMIT_N - 1);
               if (idx_ff == AW'(EMIT_N - 1)) begin
                  state_in = ffdd_pkg::EMIT_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ffdd_pkg::EMIT_READ;
               end
            end
         end
         default: begin
            state_in = ffdd_pkg::EMIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffdd_pkg::EMIT_IDLE;
         idx_ff       <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rd_addr              = idx_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data             = rsp_data_ff;
   assign emit_status.busy     = state_ff != ffdd_pkg::EMIT_IDLE;
   assign emit_status.out_full = rsp_valid_ff;

   `FFDD_ASSERT_SAME(a_done_when_idle, clock, reset, frame_done.fire,
      state_ff == ffdd_pkg::EMIT_IDLE, "frame completed while read-out busy")
   `FFDD_ASSERT_SAME(a_error_slot_free, clock, reset, frame_done.fire && !frame_done.good,
      !rsp_valid_ff, "error result with output register occupied")
   `FFDD_ASSERT_NEXT(a_error_emitted, clock, reset, frame_done.fire && !frame_done.good,
      rsp_valid_ff && rsp_data_ff.status && rsp_data_ff.last_of_run,
      "error result not loaded")
   `FFDD_ASSERT_SAME(a_burst_in_progress, clock, reset,
      rsp_valid_ff && !rsp_data_ff.last_of_run,
      state_ff != ffdd_pkg::EMIT_IDLE, "frame burst ended early")

endmodule

// File: rtl/core/fixed_frame_deframer_dispatch_top.sv
// Fixed frame deframer top: bytes in, one byte per cycle while hunting or filling unless stalled.
// A bad trailer gives one result, registered in the cycle after the trailer byte.
// A good frame streams min(FRAME_BYTES,32) results, each read through the frame
// RAM read port in READ, LOAD; input is held off until the last result is loaded.
// Synchronous reset clears control state and config; frame RAM is not cleared.
module fixed_frame_deframer_dispatch_top #(
   parameter int FRAME_BYTES    = 32,
   parameter int TRANSFER_LIMIT = 32,
   parameter int SUBSCRIBERS    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ffdd_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ffdd_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_write_enable,
   input  logic [ffdd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ffdd_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int AW = $clog2(FRAME_BYTES);

   logic [ffdd_pkg::TYPES_W-1:0]  types_ff;
   logic [ffdd_pkg::ENABLE_W-1:0] enable_ff;
   ffdd_pkg::frame_done_type      frame_done;
   ffdd_pkg::emit_status_type     emit_status;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr, rd_addr;
   logic [7:0]                    wr_data, rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         types_ff  <= '0;
         enable_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == ffdd_pkg::CSR_SUBSCRIBER_TYPES) begin
            types_ff <= csr_write_data[ffdd_pkg::TYPES_W-1:0];
         end
         if (csr_index == ffdd_pkg::CSR_SUBSCRIBER_ENABLE) begin
            enable_ff <= csr_write_data[ffdd_pkg::ENABLE_W-1:0];
         end
      end
   end

   ffdd_hunter #(
      .FRAME_BYTES    (FRAME_BYTES),
      .TRANSFER_LIMIT (TRANSFER_LIMIT),
      .SUBSCRIBERS    (SUBSCRIBERS)
   ) u_hunter (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .subscriber_types  (types_ff),
      .subscriber_enable (enable_ff),
      .emit_status       (emit_status),
      .frame_done        (frame_done),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data)
   );

   ffdd_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ffdd_emitter #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_emitter (
      .clock       (clock),
      .reset       (reset),
      .frame_done  (frame_done),
      .emit_status (emit_status),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// File: test/tb_fixed_frame_deframer_dispatch_top.sv
// Testbench for fixed_frame_deframer_dispatch_top: drives byte transactions in bursts,
// predicts frame, trailer and subscriber-mask results, and checks every result transaction.
// Depends on ffdd_pkg and the RTL top only.
`timescale 1ns / 100ps

module tb_fixed_frame_deframer_dispatch_top;

   localparam int FRAME_BYTES    = 32;
   localparam int TRANSFER_LIMIT = 32;
   localparam int SUBSCRIBERS    = 8;
   localparam int QUIET_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   ffdd_pkg::req_payload_type        req_data = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   ffdd_pkg::rsp_payload_type        rsp_data;
   logic                             csr_write_enable = 1'b0;
   logic [ffdd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ffdd_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;

   fixed_frame_deframer_dispatch_top #(
      .FRAME_BYTES(FRAME_BYTES),
      .TRANSFER_LIMIT(TRANSFER_LIMIT),
      .SUBSCRIBERS(SUBSCRIBERS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   ffdd_pkg::req_payload_type pending_bytes[$];
   ffdd_pkg::rsp_payload_type expected_results[$];
   ffdd_pkg::rsp_payload_type want_rsp;
   int              error_count = 0;

   logic [63:0] types_cfg = '0;
   logic [7:0]  enable_cfg = '0;
   logic [7:0]  frame_copy[FRAME_BYTES];
   bit          collecting = 0;
   int          fill_pos = 0;
   int          xfer_count = 0;
   logic [7:0]  ready_flags = '0;

   int          xfer_left = 1;
   int          burst_left;
   int          gap_left;
   int          gap_roll;
   int          stall_mode;
   int          mode_cycles;
   int          stall_period;
   int          stall_tick;
   int          rsp_count;
   int          hold_cycles;
   int          holds_done;
   int          quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic deframe_byte(input ffdd_pkg::req_payload_type item);
      logic [7:0]                mask;
      ffdd_pkg::rsp_payload_type res;
      int                        n;
      if (xfer_count < TRANSFER_LIMIT) begin
         xfer_count++;
         if (!collecting) begin
            if (item.rx_byte == ffdd_pkg::START_MARK) begin
               frame_copy[0] = item.rx_byte;
               fill_pos = 1;
               collecting = 1;
            end
         end else begin
            frame_copy[fill_pos] = item.rx_byte;
            fill_pos++;
            if (fill_pos == FRAME_BYTES) begin
               collecting = 0;
               fill_pos = 0;
               if (frame_copy[FRAME_BYTES-1] != ffdd_pkg::END_MARK) begin
                  res = '{status: 1'b1, frame_byte: 8'h00, byte_position: '0,
                          ready_mask: ready_flags, last_of_run: 1'b1};
                  expected_results.push_back(res);
               end else begin
                  mask = '0;
                  for (int i = 0; i < SUBSCRIBERS; i++)
                     if (enable_cfg[i] && types_cfg[8*i +: 8] == frame_copy[1])
                        mask[i] = 1'b1;
                  ready_flags = mask;
                  n = (FRAME_BYTES < ffdd_pkg::RESULT_CAP) ? FRAME_BYTES
                                                           : ffdd_pkg::RESULT_CAP;
                  for (int k = 0; k < n; k++) begin
                     res = '{status: 1'b0, frame_byte: frame_copy[k],
                             byte_position: k[ffdd_pkg::POS_W-1:0], ready_mask: mask,
                             last_of_run: (k == n - 1)};
                     expected_results.push_back(res);
                  end
               end
            end
         end
      end
      if (item.end_of_transfer)
         xfer_count = 0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 1;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall)
            deframe_byte(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_data <= pending_bytes.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 48);
                  gap_roll = $urandom_range(0, 9);
                  gap_left <= (gap_roll < 3) ? 0 :
                              (gap_roll < 8) ? $urandom_range(1, 4) : $urandom_range(5, 20);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_count <= 0;
         stall_mode <= 0;
         mode_cycles <= 0;
         stall_period <= 3;
         stall_tick <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count <= rsp_count + 1;
            if (expected_results.size() == 0) begin
               report_error($sformatf("unexpected result %p", rsp_data));
            end else begin
               want_rsp = expected_results.pop_front();
               check_field("status", 8'(rsp_data.status), 8'(want_rsp.status));
               check_field("frame_byte", rsp_data.frame_byte, want_rsp.frame_byte);
               check_field("byte_position", 8'(rsp_data.byte_position),
                           8'(want_rsp.byte_position));
               check_field("ready_mask", rsp_data.ready_mask, want_rsp.ready_mask);
               check_field("last_of_run", 8'(rsp_data.last_of_run),
                           8'(want_rsp.last_of_run));
            end
         end
         if (mode_cycles == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_cycles <= $urandom_range(50, 300);
            stall_period <= $urandom_range(3, 7);
         end else begin
            mode_cycles <= mode_cycles - 1;
         end
         stall_tick <= stall_tick + 1;
         rsp_stall <= (hold_cycles != 0) ||
                      (stall_mode == 1 && (stall_tick % stall_period) < 2) ||
                      (stall_mode == 2 && $urandom_range(0, 3) == 0);
      end
   end

   // long receiver hold-off while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         holds_done <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (holds_done < 2 && rsp_count >= (holds_done == 0 ? 20 : 250)) begin
         hold_cycles <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input logic [ffdd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == ffdd_pkg::CSR_SUBSCRIBER_TYPES)
         types_cfg = value;
      else
         enable_cfg = value[ffdd_pkg::ENABLE_W-1:0];
   endtask

   task automatic set_subscribers(input logic [63:0] types, input logic [7:0] enables);
      write_csr(ffdd_pkg::CSR_SUBSCRIBER_TYPES, types);
      write_csr(ffdd_pkg::CSR_SUBSCRIBER_ENABLE, {56'h0, enables});
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic int new_transfer_len();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, TRANSFER_LIMIT)
                                           : $urandom_range(TRANSFER_LIMIT + 1, 40);
   endfunction

   task automatic push_item(input logic [7:0] b, input logic eot);
      ffdd_pkg::req_payload_type item;
      item.rx_byte = b;
      item.end_of_transfer = eot;
      pending_bytes.push_back(item);
   endtask

   task automatic push_stream_byte(input logic [7:0] b);
      push_item(b, xfer_left == 1);
      xfer_left--;
      if (xfer_left == 0)
         xfer_left = new_transfer_len();
   endtask

   // eot_at < 0: follow the running transfer length
   task automatic push_frame(input logic [7:0] frame_kind, input logic [7:0] trailer,
                             input int eot_at);
      logic [7:0] b;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         b = (k == 0) ? ffdd_pkg::START_MARK : (k == 1) ? frame_kind :
             (k == FRAME_BYTES - 1) ? trailer : 8'($urandom);
         if (eot_at < 0)
            push_stream_byte(b);
         else
            push_item(b, k == eot_at);
      end
   endtask

   task automatic add_traffic(input int n);
      int         roll;
      logic [7:0] frame_kind;
      while (pending_bytes.size() < n) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            frame_kind = ($urandom_range(0, 3) != 0) ? types_cfg[8*$urandom_range(0, 7) +: 8]
                                                     : 8'($urandom);
            push_frame(frame_kind,
                       ($urandom_range(0, 3) != 0) ? ffdd_pkg::END_MARK : 8'($urandom), -1);
         end else if (roll < 85) begin
            repeat ($urandom_range(1, 4)) push_stream_byte(8'($urandom));
         end else begin
            push_stream_byte(ffdd_pkg::START_MARK);
            repeat ($urandom_range(1, FRAME_BYTES - 2)) push_stream_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      logic [63:0] types;
      logic [7:0]  choices[5];
      choices = '{8'h00, ffdd_pkg::START_MARK, ffdd_pkg::END_MARK, 8'hFF, 8'h42};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_subscribers(64'h1165_1173_0011_FF11, 8'hFF);
      @(negedge clock);
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b1);
      push_item(ffdd_pkg::END_MARK, 1'b0);
      push_item(8'h01, 1'b1);
      push_frame(8'h11, ffdd_pkg::END_MARK, FRAME_BYTES - 1);
      push_frame(8'hFF, 8'h00, FRAME_BYTES);
      push_item(ffdd_pkg::START_MARK, 1'b0);
      push_item(8'hFF, 1'b1);
      push_frame(ffdd_pkg::START_MARK, ffdd_pkg::END_MARK, 9);
      push_item(8'h00, 1'b1);
      xfer_left = new_transfer_len();
      wait_drained();
      add_traffic(70);
      wait_drained();

      set_subscribers(64'h0, 8'h00);
      add_traffic(60);
      wait_drained();

      set_subscribers({64{1'b1}}, 8'hFF);
      add_traffic(60);
      wait_drained();

      set_subscribers({$urandom, $urandom}, 8'($urandom));
      add_traffic(60);
      wait_drained();

      for (int i = 0; i < 8; i++)
         types[8*i +: 8] = choices[$urandom_range(0, 4)];
      set_subscribers(types, 8'($urandom));
      add_traffic(60);
      wait_drained();

      if (expected_results.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_results.size()));
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
